// ----- hw/rtl/csb_pkg.sv -----
`default_nettype none

package csb_pkg;

  // Clip register widths and reset values.
  localparam int CLIP_X_W = 9;
  localparam int CLIP_Y_W = 8;
  localparam int CFG_W = 9;
  localparam logic [CLIP_X_W-1:0] CLIP_RIGHT_RST = 9'd319;
  localparam logic [CLIP_Y_W-1:0] CLIP_BOTTOM_RST = 8'd199;

  // Screen coordinates: 16-bit signed origin plus a 16-bit unsigned count.
  localparam int COORD_W = 18;

  // Queue between classifier and draw pipeline, and the reply queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_PIXEL,
    KIND_TABLE,
    KIND_READ
  } kind_t;

  typedef enum logic [1:0] {
    MODE_COPY,
    MODE_SKIP_ZERO,
    MODE_XLATE_SRC,
    MODE_XLATE_DST
  } mode_t;

  typedef enum logic {
    REPLY_WRITE,
    REPLY_READ
  } reply_kind_t;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT,
    REG_CLIP_TOP,
    REG_CLIP_RIGHT,
    REG_CLIP_BOTTOM
  } cfg_reg_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        sprite_width;
    logic [15:0]        sprite_height;
    mode_t              draw_mode;
    logic [7:0]         pixel_index;
    logic [7:0]         table_slot;
    logic [7:0]         table_value;
    logic [15:0]        read_address;
  } item_t;

  typedef struct packed {
    reply_kind_t reply_kind;
    logic [15:0] frame_address;
    logic [7:0]  frame_value;
  } reply_t;

  // Work handed from the classifier to the draw pipeline.
  typedef struct packed {
    kind_t       op;
    mode_t       mode;
    logic [7:0]  data;
    logic [7:0]  slot;
    logic [15:0] reply_addr;
    logic        zero_read;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/clipped_sprite_blitter.sv -----
`default_nettype none

// Sprite blitter with a clip rectangle. It holds a SCREEN_WIDTH by
// SCREEN_HEIGHT frame store of 8-bit color indexes. A header word opens a
// sprite (origin, size, draw mode); the pixel words that follow in raster
// order are drawn when they land inside both the clip rectangle and the
// screen, and every pixel drawn is reported on the reply channel with its
// address and final value. Table words load the 256-entry translation
// table; read words return one frame byte, or zero beyond the frame.
// Draw modes are copy, skip index zero, translate the source through the
// table, and translate the current frame byte through the table; all modes
// but copy skip source index zero. The block takes one word per clock
// whenever the reply side keeps up. A word passes through the classifier
// register (clip and address), waits in the command queue while the frame
// store is read, then moves through the draw pipeline (table read, then
// frame write) and its reply enters the reply queue; the one-word-per-clock
// figure is set by the single frame store write port, and read-modify-write
// hazards between neighboring pixels are forwarded so they never stall.
// After reset the block sweeps the frame store to zero, one byte a cycle,
// over all SCREEN_WIDTH * SCREEN_HEIGHT bytes (64000 by default); item_stall
// stays high meanwhile, while clip register writes are taken as usual.
module clipped_sprite_blitter #(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [csb_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        item_valid,
  input  wire csb_pkg::item_t              item,
  output logic                             item_stall,
  output logic                             reply_valid,
  output csb_pkg::reply_t                  reply,
  input  wire logic                        reply_stall
);

  localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int FA_W = $clog2(FRAME_SIZE);
  localparam int QW = $bits(csb_pkg::cmd_t) + FA_W;
  localparam int OW = $bits(csb_pkg::reply_t);

  logic                            busy;
  logic                            push;
  csb_pkg::cmd_t                   push_cmd;
  logic [FA_W-1:0]                 push_addr;
  logic [QW-1:0]                   q_head;
  logic [csb_pkg::Q_CNT_W-1:0]     q_count;
  logic                            q_full;
  logic                            pop;
  csb_pkg::cmd_t                   head_cmd;
  logic [FA_W-1:0]                 head_addr;
  logic                            out_push;
  csb_pkg::reply_t                 out_word;
  logic [OW-1:0]                   out_head;
  logic [csb_pkg::OUT_CNT_W-1:0]   out_count;

  // The classifier drops words that draw nothing (headers, clipped or
  // skipped pixels); everything else waits here for the draw pipeline.
  assign q_full = q_count == csb_pkg::Q_CNT_W'(csb_pkg::Q_DEPTH);
  assign head_cmd = csb_pkg::cmd_t'(q_head[QW-1:FA_W]);
  assign head_addr = q_head[FA_W-1:0];

  // Replies leave from a small queue so a stalled consumer does not hold
  // up the pipeline until it has filled.
  assign reply_valid = out_count != '0;
  assign reply = csb_pkg::reply_t'(out_head);

  csb_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_valid(item_valid),
    .item      (item),
    .item_stall(item_stall),
    .busy      (busy),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr)
  );

  csb_fifo #(
    .WIDTH(QW),
    .DEPTH(csb_pkg::Q_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  ({push_cmd, push_addr}),
    .pop  (pop),
    .head (q_head),
    .count(q_count)
  );

  csb_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_count != '0),
    .head_cmd  (head_cmd),
    .head_addr (head_addr),
    .pop       (pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_word  (out_word),
    .clearing  (busy)
  );

  csb_fifo #(
    .WIDTH(OW),
    .DEPTH(csb_pkg::OUT_DEPTH)
  ) u_reply_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .din  (out_word),
    .pop  (reply_valid && !reply_stall),
    .head (out_head),
    .count(out_count)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/csb_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read; a read at the
// address being written returns the old contents.
module csb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/csb_fifo.sv -----
`default_nettype none

// Small register FIFO. The caller never pushes when full or pops when empty.
module csb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head,
  output logic      [CW-1:0]    count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW-1:0] wptr_next;
  logic [PW-1:0] rptr_next;

  assign wptr_next = (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
  assign rptr_next = (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr_next;
      end
      if (pop) begin
        rptr <= rptr_next;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/csb_front.sv -----
`default_nettype none

// Accepts words, tracks the sprite raster position, clips pixels and
// turns each word that needs the frame store or the table into a command.
module csb_front #(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_HEIGHT = 200,
  localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT,
  localparam int FA_W = $clog2(FRAME_SIZE),
  localparam int CW = $clog2(SCREEN_WIDTH),
  localparam int RW = $clog2(SCREEN_HEIGHT)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [csb_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                    item_valid,
  input  wire csb_pkg::item_t          item,
  output logic                         item_stall,
  input  wire logic                    busy,
  input  wire logic                    q_full,
  output logic                         push,
  output csb_pkg::cmd_t                push_cmd,
  output logic      [FA_W-1:0]         push_addr
);

  localparam int CO = csb_pkg::COORD_W;

  logic [csb_pkg::CLIP_X_W-1:0] clip_left;
  logic [csb_pkg::CLIP_Y_W-1:0] clip_top;
  logic [csb_pkg::CLIP_X_W-1:0] clip_right;
  logic [csb_pkg::CLIP_Y_W-1:0] clip_bottom;

  logic signed [15:0] cur_origin_x;
  logic signed [15:0] cur_origin_y;
  logic [15:0]        cur_width;
  logic [15:0]        cur_height;
  csb_pkg::mode_t     cur_mode;
  logic [15:0]        column_count;
  logic [15:0]        row_count;

  logic               f1_v;
  csb_pkg::kind_t     f1_kind;
  csb_pkg::mode_t     f1_mode;
  logic signed [CO-1:0] f1_col;
  logic signed [CO-1:0] f1_row;
  logic [7:0]         f1_data;
  logic [7:0]         f1_slot;
  logic [15:0]        f1_raddr;

  logic               accept;
  logic               pixel_live;
  logic               col_wrap;
  logic               load_f1;
  logic               drain;
  logic signed [CO-1:0] col_at;
  logic signed [CO-1:0] row_at;

  logic [CO-2:0]      col_u;
  logic [CO-2:0]      row_u;
  logic               in_clip;
  logic               skip;
  logic [31:0]        addr_full;
  logic               has_work;

  assign item_stall = busy || (f1_v && q_full);
  assign accept = item_valid && !item_stall;
  assign drain = f1_v && !q_full;

  assign pixel_live = (cur_width != 16'd0) && (row_count < cur_height);
  assign col_wrap = ({1'b0, column_count} + 17'd1) >= {1'b0, cur_width};
  assign col_at = CO'(cur_origin_x) + CO'($signed({1'b0, column_count}));
  assign row_at = CO'(cur_origin_y) + CO'($signed({1'b0, row_count}));

  always_comb begin
    load_f1 = 1'b0;
    if (accept) begin
      case (item.kind)
        csb_pkg::KIND_PIXEL: load_f1 = pixel_live;
        csb_pkg::KIND_TABLE: load_f1 = 1'b1;
        csb_pkg::KIND_READ: load_f1 = 1'b1;
        default: load_f1 = 1'b0;
      endcase
    end
  end

  // Clip registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_right  <= csb_pkg::CLIP_RIGHT_RST;
      clip_bottom <= csb_pkg::CLIP_BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        csb_pkg::REG_CLIP_LEFT: clip_left <= cfg_data[csb_pkg::CLIP_X_W-1:0];
        csb_pkg::REG_CLIP_TOP: clip_top <= cfg_data[csb_pkg::CLIP_Y_W-1:0];
        csb_pkg::REG_CLIP_RIGHT: clip_right <= cfg_data[csb_pkg::CLIP_X_W-1:0];
        csb_pkg::REG_CLIP_BOTTOM: clip_bottom <= cfg_data[csb_pkg::CLIP_Y_W-1:0];
        default: clip_left <= clip_left;
      endcase
    end
  end

  // Sprite header and raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_origin_x <= '0;
      cur_origin_y <= '0;
      cur_width    <= '0;
      cur_height   <= '0;
      cur_mode     <= csb_pkg::MODE_COPY;
      column_count <= '0;
      row_count    <= '0;
    end else if (accept && item.kind == csb_pkg::KIND_HEADER) begin
      cur_origin_x <= item.origin_x;
      cur_origin_y <= item.origin_y;
      cur_width    <= item.sprite_width;
      cur_height   <= item.sprite_height;
      cur_mode     <= item.draw_mode;
      column_count <= '0;
      row_count    <= '0;
    end else if (accept && item.kind == csb_pkg::KIND_PIXEL && pixel_live) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_count + 16'd1;
      end else begin
        column_count <= column_count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (load_f1) begin
      f1_v <= 1'b1;
    end else if (drain) begin
      f1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_f1) begin
      f1_kind  <= item.kind;
      f1_mode  <= cur_mode;
      f1_col   <= col_at;
      f1_row   <= row_at;
      f1_data  <= (item.kind == csb_pkg::KIND_TABLE) ? item.table_value : item.pixel_index;
      f1_slot  <= item.table_slot;
      f1_raddr <= item.read_address;
    end
  end

  // Clip test and frame address of the classified word.
  assign col_u = f1_col[CO-2:0];
  assign row_u = f1_row[CO-2:0];
  assign in_clip = !f1_col[CO-1] && !f1_row[CO-1] &&
                   (col_u >= (CO-1)'(clip_left)) && (col_u <= (CO-1)'(clip_right)) &&
                   (row_u >= (CO-1)'(clip_top)) && (row_u <= (CO-1)'(clip_bottom)) &&
                   (col_u < (CO-1)'(SCREEN_WIDTH)) && (row_u < (CO-1)'(SCREEN_HEIGHT));
  assign skip = (f1_mode != csb_pkg::MODE_COPY) && (f1_data == 8'd0);
  assign addr_full = 32'(f1_row[RW-1:0]) * 32'(SCREEN_WIDTH) + 32'(f1_col[CW-1:0]);

  always_comb begin
    has_work = 1'b0;
    push_cmd.op = f1_kind;
    push_cmd.mode = f1_mode;
    push_cmd.data = f1_data;
    push_cmd.slot = f1_slot;
    push_cmd.reply_addr = 16'(addr_full);
    push_cmd.zero_read = 1'b0;
    push_addr = FA_W'(addr_full);
    case (f1_kind)
      csb_pkg::KIND_PIXEL: has_work = in_clip && !skip;
      csb_pkg::KIND_TABLE: has_work = 1'b1;
      csb_pkg::KIND_READ: begin
        has_work = 1'b1;
        push_cmd.reply_addr = f1_raddr;
        push_cmd.zero_read = 32'(f1_raddr) >= 32'(FRAME_SIZE);
        push_addr = FA_W'(f1_raddr);
      end
      default: has_work = 1'b0;
    endcase
  end

  assign push = drain && has_work;

endmodule

`default_nettype wire

// ----- hw/rtl/csb_back.sv -----
`default_nettype none

// Draw pipeline: frame read, table lookup, frame write and reply, with
// forwarding of the two most recent frame writes into the read stage.
module csb_back #(
  parameter int SCREEN_WIDTH = 320,
  parameter int SCREEN_HEIGHT = 200,
  localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT,
  localparam int FA_W = $clog2(FRAME_SIZE)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  wire csb_pkg::cmd_t                 head_cmd,
  input  wire logic [FA_W-1:0]               head_addr,
  output logic                               pop,
  input  wire logic [csb_pkg::OUT_CNT_W-1:0] out_count,
  output logic                               out_push,
  output csb_pkg::reply_t                    out_word,
  output logic                               clearing
);

  localparam int UW = csb_pkg::OUT_CNT_W + 1;

  logic [FA_W-1:0] clr_addr;

  logic            b1_v;
  csb_pkg::cmd_t   b1_cmd;
  logic [FA_W-1:0] b1_addr;

  logic            b2_v;
  csb_pkg::cmd_t   b2_cmd;
  logic [FA_W-1:0] b2_addr;
  logic [7:0]      b2_byte;

  logic            wl_v;
  logic [FA_W-1:0] wl_addr;
  logic [7:0]      wl_val;

  logic [UW-1:0]   used;
  logic [7:0]      frame_rd;
  logic [7:0]      tbl_rd;
  logic [7:0]      fwd_byte;
  logic [7:0]      tbl_raddr;
  logic            tbl_we;
  logic            b2_write;
  logic [7:0]      b2_val;
  logic            fr_we;
  logic [FA_W-1:0] fr_waddr;
  logic [7:0]      fr_wdata;

  // Reply space is reserved before a command enters, so the pipeline
  // never has to hold.
  assign used = UW'(out_count) + UW'(b1_v) + UW'(b2_v);
  assign pop = head_valid && !clearing && (used < UW'(csb_pkg::OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == FA_W'(FRAME_SIZE - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      wl_v <= 1'b0;
    end else begin
      b1_v <= pop;
      b2_v <= b1_v;
      wl_v <= b2_write;
    end
  end

  always_ff @(posedge clk) begin
    b1_cmd  <= head_cmd;
    b1_addr <= head_addr;
    b2_cmd  <= b1_cmd;
    b2_addr <= b1_addr;
    b2_byte <= fwd_byte;
    wl_addr <= b2_addr;
    wl_val  <= b2_val;
  end

  // The write in flight this cycle is newer than the one just retired.
  always_comb begin
    if (b2_write && b2_addr == b1_addr) begin
      fwd_byte = b2_val;
    end else if (wl_v && wl_addr == b1_addr) begin
      fwd_byte = wl_val;
    end else begin
      fwd_byte = frame_rd;
    end
  end

  assign tbl_raddr = (b1_cmd.mode == csb_pkg::MODE_XLATE_DST) ? fwd_byte : b1_cmd.data;
  assign tbl_we = b1_v && b1_cmd.op == csb_pkg::KIND_TABLE;

  always_comb begin
    case (b2_cmd.op)
      csb_pkg::KIND_READ: b2_val = b2_cmd.zero_read ? 8'd0 : b2_byte;
      default: begin
        if (b2_cmd.mode inside {csb_pkg::MODE_XLATE_SRC, csb_pkg::MODE_XLATE_DST}) begin
          b2_val = tbl_rd;
        end else begin
          b2_val = b2_cmd.data;
        end
      end
    endcase
  end

  assign b2_write = b2_v && b2_cmd.op == csb_pkg::KIND_PIXEL;
  assign fr_we = clearing || b2_write;
  assign fr_waddr = clearing ? clr_addr : b2_addr;
  assign fr_wdata = clearing ? 8'd0 : b2_val;

  assign out_push = b2_v && (b2_cmd.op inside {csb_pkg::KIND_PIXEL, csb_pkg::KIND_READ});
  assign out_word.reply_kind = (b2_cmd.op == csb_pkg::KIND_READ) ?
                               csb_pkg::REPLY_READ : csb_pkg::REPLY_WRITE;
  assign out_word.frame_address = b2_cmd.reply_addr;
  assign out_word.frame_value = b2_val;

  csb_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_SIZE)
  ) u_frame (
    .clk  (clk),
    .we   (fr_we),
    .waddr(fr_waddr),
    .wdata(fr_wdata),
    .raddr(head_addr),
    .rdata(frame_rd)
  );

  csb_ram #(
    .WIDTH(8),
    .DEPTH(256)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(b1_cmd.slot),
    .wdata(b1_cmd.data),
    .raddr(tbl_raddr),
    .rdata(tbl_rd)
  );

endmodule

`default_nettype wire
